>>> hdl/srasl_pkg.sv
// Shared constants and types for the spike-rejecting average with slew limit.
package srasl_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int CFG_W          = 16;
   localparam int OUT_CNT_W      = 3;
   localparam int RANK_W         = 2;
   localparam int WINDOW_DEFAULT = 5;
   localparam int CSR_INDEX_W    = 1;

   localparam logic [CFG_W-1:0]     TOLERANCE_RESET = 16'd64;
   localparam logic [CFG_W-1:0]     MAX_STEP_RESET  = 16'd50;
   localparam logic [OUT_CNT_W-1:0] OUT_CNT_MAX     = 3'd7;
   // outliers that are replaced by the reference value
   localparam logic [RANK_W-1:0]    REPLACE_LIMIT   = 2'd2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TOLERANCE = 1'b0,
      CSR_MAX_STEP  = 1'b1
   } csr_index_type;

   // neighbor link between window cells
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [RANK_W-1:0]          rank;
   } link_type;

endpackage

>>> hdl/spike_reject_average_slew_limit.sv
// Top level: window cell chain, running window sum, CSRs and result pipeline.
// A result goes through the stage 1, 2, 3 and output registers. Throughput: one
// transaction per cycle while req_stall is low; the window cell chain compares all
// samples in the accept cycle, the divide by WINDOW is a reciprocal multiply stage.
// Reset (synchronous): window and running sum cleared to zero, tolerance = 64,
// max_step = 50, pipeline emptied.
module spike_reject_average_slew_limit #(
   parameter int WINDOW = srasl_pkg::WINDOW_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic signed [srasl_pkg::SAMPLE_W-1:0]   req_new_sample,
   input  logic signed [srasl_pkg::SAMPLE_W-1:0]   req_reference,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [srasl_pkg::SAMPLE_W-1:0]   rsp_filtered,
   output logic [srasl_pkg::OUT_CNT_W-1:0]         rsp_outlier_count,
   output logic                                    rsp_slew_limited,
   input  logic                                    csr_write_enable,
   input  logic [srasl_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [srasl_pkg::CFG_W-1:0]             csr_write_data
);

   localparam int CW    = $clog2(WINDOW);
   localparam int SUM_W = srasl_pkg::SAMPLE_W + 1 + CW;
   localparam int CNT_W = ($clog2(WINDOW + 1) > srasl_pkg::OUT_CNT_W) ?
                          $clog2(WINDOW + 1) : srasl_pkg::OUT_CNT_W;
   localparam int BAND_W = srasl_pkg::SAMPLE_W + 2;

   logic [srasl_pkg::CFG_W-1:0] tolerance_ff, max_step_ff;

   srasl_pkg::link_type                   links [WINDOW+1];
   logic [WINDOW-1:0]                     outliers;
   logic signed [srasl_pkg::SAMPLE_W:0]   corr_first  [WINDOW];
   logic signed [srasl_pkg::SAMPLE_W:0]   corr_second [WINDOW];
   logic signed [srasl_pkg::SAMPLE_W:0]   corr1_in, corr2_in;
   logic signed [BAND_W-1:0]              band_lo, band_hi;

   logic                                  accept, s1_ready, tail_ready;
   logic signed [SUM_W-1:0]               wsum_ff, wsum_in;
   logic [CNT_W-1:0]                      ones;
   logic [srasl_pkg::OUT_CNT_W-1:0]       cnt_in;

   logic                                  v1_ff;
   logic signed [SUM_W-1:0]               base1_ff;
   logic signed [srasl_pkg::SAMPLE_W:0]   corr1_ff, corr2_ff;
   logic [srasl_pkg::OUT_CNT_W-1:0]       cnt1_ff;
   logic signed [srasl_pkg::SAMPLE_W-1:0] ref1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tolerance_ff <= srasl_pkg::TOLERANCE_RESET;
         max_step_ff  <= srasl_pkg::MAX_STEP_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            srasl_pkg::CSR_TOLERANCE: tolerance_ff <= csr_write_data;
            srasl_pkg::CSR_MAX_STEP:  max_step_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign s1_ready  = !v1_ff || tail_ready;
   assign req_stall = !s1_ready;
   assign accept    = req_valid && s1_ready;

   assign band_lo = BAND_W'(req_reference) - BAND_W'(tolerance_ff);
   assign band_hi = BAND_W'(req_reference) + BAND_W'(tolerance_ff);

   assign links[0].sample = req_new_sample;
   assign links[0].rank   = '0;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      srasl_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .shift       (accept),
         .band_lo     (band_lo),
         .band_hi     (band_hi),
         .reference   (req_reference),
         .link_in     (links[i]),
         .link_out    (links[i+1]),
         .outlier     (outliers[i]),
         .corr_first  (corr_first[i]),
         .corr_second (corr_second[i])
      );
   end

   always_comb begin
      corr1_in = '0;
      corr2_in = '0;
      for (int i = 0; i < WINDOW; i++) begin
         corr1_in = corr1_in | corr_first[i];
         corr2_in = corr2_in | corr_second[i];
      end
      ones   = CNT_W'($countones(outliers));
      cnt_in = (ones > CNT_W'(srasl_pkg::OUT_CNT_MAX)) ?
               srasl_pkg::OUT_CNT_MAX : ones[srasl_pkg::OUT_CNT_W-1:0];
      wsum_in = wsum_ff + SUM_W'(req_new_sample) - SUM_W'(links[WINDOW].sample);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wsum_ff <= '0;
         v1_ff   <= 1'b0;
      end else begin
         if (accept) begin
            wsum_ff <= wsum_in;
         end
         if (s1_ready) begin
            v1_ff <= req_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         base1_ff <= wsum_in;
         corr1_ff <= corr1_in;
         corr2_ff <= corr2_in;
         cnt1_ff  <= cnt_in;
         ref1_ff  <= req_reference;
      end
   end

   srasl_tail #(.WINDOW(WINDOW)) u_tail (
      .clock             (clock),
      .reset             (reset),
      .in_valid          (v1_ff),
      .in_ready          (tail_ready),
      .in_base           (base1_ff),
      .in_corr1          (corr1_ff),
      .in_corr2          (corr2_ff),
      .in_count          (cnt1_ff),
      .in_reference      (ref1_ff),
      .max_step          (max_step_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_filtered      (rsp_filtered),
      .rsp_outlier_count (rsp_outlier_count),
      .rsp_slew_limited  (rsp_slew_limited)
   );

endmodule

>>> hdl/srasl_cell.sv
// One window cell: holds a sample, tests the incoming sample against the band, ranks outliers.
module srasl_cell (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  shift,
   input  logic signed [srasl_pkg::SAMPLE_W+1:0] band_lo,
   input  logic signed [srasl_pkg::SAMPLE_W+1:0] band_hi,
   input  logic signed [srasl_pkg::SAMPLE_W-1:0] reference,
   input  srasl_pkg::link_type                   link_in,
   output srasl_pkg::link_type                   link_out,
   output logic                                  outlier,
   output logic signed [srasl_pkg::SAMPLE_W:0]   corr_first,
   output logic signed [srasl_pkg::SAMPLE_W:0]   corr_second
);

   logic signed [srasl_pkg::SAMPLE_W-1:0] sample_ff;
   logic signed [srasl_pkg::SAMPLE_W+1:0] value_ext;
   logic signed [srasl_pkg::SAMPLE_W:0]   delta;
   logic [srasl_pkg::RANK_W-1:0]          rank_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (shift) begin
         sample_ff <= link_in.sample;
      end
   end

   always_comb begin
      value_ext = (srasl_pkg::SAMPLE_W+2)'(link_in.sample);
      outlier   = !((value_ext > band_lo) && (value_ext < band_hi));
      delta     = (srasl_pkg::SAMPLE_W+1)'(reference) -
                  (srasl_pkg::SAMPLE_W+1)'(link_in.sample);
      rank_next = link_in.rank;
      if (outlier && (link_in.rank != srasl_pkg::REPLACE_LIMIT)) begin
         rank_next = link_in.rank + 1'b1;
      end
      corr_first  = (outlier && (link_in.rank == '0)) ? delta : '0;
      corr_second = (outlier && (link_in.rank == 2'd1)) ? delta : '0;
   end

   assign link_out.sample = sample_ff;
   assign link_out.rank   = rank_next;

endmodule

>>> hdl/srasl_tail.sv
// Sum, divide by window length and slew clamp pipeline with output register.
module srasl_tail #(
   parameter int WINDOW = srasl_pkg::WINDOW_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic signed [srasl_pkg::SAMPLE_W+$clog2(WINDOW):0] in_base,
   input  logic signed [srasl_pkg::SAMPLE_W:0]     in_corr1,
   input  logic signed [srasl_pkg::SAMPLE_W:0]     in_corr2,
   input  logic [srasl_pkg::OUT_CNT_W-1:0]         in_count,
   input  logic signed [srasl_pkg::SAMPLE_W-1:0]   in_reference,
   input  logic [srasl_pkg::CFG_W-1:0]             max_step,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic signed [srasl_pkg::SAMPLE_W-1:0]   rsp_filtered,
   output logic [srasl_pkg::OUT_CNT_W-1:0]         rsp_outlier_count,
   output logic                                    rsp_slew_limited
);

   localparam int CW      = $clog2(WINDOW);
   localparam int SUM_W   = srasl_pkg::SAMPLE_W + 1 + CW;
   localparam int MAG_W   = srasl_pkg::SAMPLE_W + CW;
   localparam int SHIFT_K = MAG_W + CW;
   localparam int RECIP_W = SHIFT_K;
   localparam int PROD_W  = MAG_W + RECIP_W;
   localparam int AVG_W   = srasl_pkg::SAMPLE_W + 2;
   localparam longint unsigned RECIP_L =
      ((longint'(1) << SHIFT_K) + longint'(WINDOW) - 1) / longint'(WINDOW);
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);

   logic rdy_out, rdy3, rdy2;
   logic v2_ff, v3_ff, rsp_valid_ff;

   logic signed [SUM_W-1:0]                sum_in;
   logic                                   neg2_ff, neg2_in, neg3_ff;
   logic [MAG_W-1:0]                       mag2_ff, mag2_in;
   logic [srasl_pkg::OUT_CNT_W-1:0]        cnt2_ff, cnt3_ff, cnt_out_ff;
   logic signed [srasl_pkg::SAMPLE_W-1:0]  ref2_ff, ref3_ff;
   logic [PROD_W-1:0]                      prod3_ff, prod3_in;

   logic [srasl_pkg::SAMPLE_W-1:0]         quot;
   logic signed [AVG_W-1:0]                avg, ref_ext, upper, lower;
   logic signed [srasl_pkg::SAMPLE_W-1:0]  filt_in, filt_ff;
   logic                                   slew_in, slew_ff;

   assign rdy_out  = !rsp_valid_ff || !rsp_stall;
   assign rdy3     = !v3_ff || rdy_out;
   assign rdy2     = !v2_ff || rdy3;
   assign in_ready = rdy2;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy2) begin
            v2_ff <= in_valid;
         end
         if (rdy3) begin
            v3_ff <= v2_ff;
         end
         if (rdy_out) begin
            rsp_valid_ff <= v3_ff;
         end
      end
   end

   always_comb begin
      sum_in  = in_base + SUM_W'(in_corr1) + SUM_W'(in_corr2);
      neg2_in = sum_in[SUM_W-1];
      mag2_in = neg2_in ? MAG_W'(-sum_in) : MAG_W'(sum_in);
   end

   assign prod3_in = mag2_ff * RECIP;

   always_comb begin
      quot    = prod3_ff[SHIFT_K +: srasl_pkg::SAMPLE_W];
      avg     = neg3_ff ? -AVG_W'(quot) : AVG_W'(quot);
      ref_ext = AVG_W'(ref3_ff);
      upper   = ref_ext + AVG_W'(max_step);
      lower   = ref_ext - AVG_W'(max_step);
      filt_in = avg[srasl_pkg::SAMPLE_W-1:0];
      slew_in = 1'b0;
      if (upper < avg) begin
         filt_in = upper[srasl_pkg::SAMPLE_W-1:0];
         slew_in = 1'b1;
      end else if (lower > avg) begin
         filt_in = lower[srasl_pkg::SAMPLE_W-1:0];
         slew_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2) begin
         neg2_ff <= neg2_in;
         mag2_ff <= mag2_in;
         cnt2_ff <= in_count;
         ref2_ff <= in_reference;
      end
      if (rdy3) begin
         neg3_ff  <= neg2_ff;
         prod3_ff <= prod3_in;
         cnt3_ff  <= cnt2_ff;
         ref3_ff  <= ref2_ff;
      end
      if (rdy_out) begin
         filt_ff    <= filt_in;
         slew_ff    <= slew_in;
         cnt_out_ff <= cnt3_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_filtered      = filt_ff;
   assign rsp_outlier_count = cnt_out_ff;
   assign rsp_slew_limited  = slew_ff;

endmodule

>>> hdl/srasl_checker.sv
// Port-level assertion checker for the top level, attached by bind.
module srasl_checker #(
   parameter int WINDOW = srasl_pkg::WINDOW_DEFAULT
) (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_stall,
   input logic                                  rsp_valid,
   input logic                                  rsp_stall,
   input logic signed [srasl_pkg::SAMPLE_W-1:0] rsp_filtered,
   input logic [srasl_pkg::OUT_CNT_W-1:0]       rsp_outlier_count
);

   localparam logic [srasl_pkg::OUT_CNT_W-1:0] CNT_LIMIT =
      (WINDOW > 7) ? srasl_pkg::OUT_CNT_MAX : srasl_pkg::OUT_CNT_W'(WINDOW);

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_no_stall_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while result side is free");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall ##1 !rsp_stall ##1 !rsp_stall
      |=> rsp_valid)
      else $error("accepted transaction did not reach the result port");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_outlier_count <= CNT_LIMIT))
      else $error("outlier count out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_filtered)))
      else $error("stalled result changed");

endmodule

bind spike_reject_average_slew_limit srasl_checker #(.WINDOW(WINDOW)) u_srasl_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_filtered      (rsp_filtered),
   .rsp_outlier_count (rsp_outlier_count)
);
